// ===== hw/rtl/grp_pkg.sv =====
// Package for the guillotine rectangle packer: sizes, payload structs,
// controller states and the command/status structs. No dependencies.
package grp_pkg;
  localparam int unsigned MaxBins     = 16;
  localparam int unsigned MaxAreas    = 32;
  localparam int unsigned NumBinTypes = 4;
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned BinBits     = $clog2(MaxBins);
  localparam int unsigned AreaBits    = $clog2(MaxAreas);
  localparam int unsigned AddrBits    = BinBits + AreaBits;
  localparam int unsigned CntBits     = AreaBits + 1;
  localparam int unsigned ObcBits     = BinBits + 1;
  localparam int unsigned AreaW       = 4 * CoordBits;

  localparam logic [1:0] StPlaced = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StCleared = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] item_id;
    logic [15:0] item_width;
    logic [15:0] item_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [3:0]  bin_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        new_bin;
    logic [1:0]  bin_type;
  } out_item_t;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
  } area_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_SPLIT2, S_OPEN, S_OPEN2, S_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture the input item
    logic clear;     // clear all bins
    logic rd;        // read phase at the scan pointer (not used by the datapath)
    logic step;      // advance the scan pointer
    logic wr_below;  // write the below part to the hit slot
    logic wr_right;  // write the right part, bump count
    logic open_bin;  // open a bin of the chosen type
    logic set_full;  // result: area list full
    logic set_nosp;  // result: no space
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic scan_done; // no more areas to scan
    logic fits;      // read area holds the item
    logic bin_full;  // hit bin list is full
    logic bins_full; // MaxBins already open
    logic type_ok;   // some bin type can be opened
  } sts_t;
endpackage

// ===== hw/rtl/guillotine_rect_packer.sv =====
// Guillotine first-fit rectangle packer, top level.
// Channels: in (valid/ready, in_item_t), out (valid/ready, out_item_t), and a
// plain register write port for the four bin type registers.
// Each rectangle scans the open bins in order, one free area at a time
// (memory read in S_READ, then fit check in S_CHECK), over up to 16 bins of
// 32 areas; the scan through the area RAM sets how long an item takes. A clear
// item goes from S_READ straight to S_OUT. One item is in flight at a time;
// the next is taken once the result transfer has completed.
// Result: placed (bin, x, y, new-bin flag, type), no space, area list full, or
// cleared. A rectangle that opens a bin writes in S_OPEN, then S_OPEN2.
// Reset: all bins closed, type registers zero; the area RAM is not cleared,
// since per-bin counts gate every read.
// When the receiver stalls, hold the result on the output and take no input.
module guillotine_rect_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  grp_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output grp_pkg::out_item_t  out_data_o
);
  grp_pkg::cmd_t cmd;
  grp_pkg::sts_t sts;

  grp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  grp_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_data_o
  );
endmodule

// ===== hw/rtl/grp_ram.sv =====
// Generic dual-port RAM with registered read.
// No dependencies.
module grp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/grp_ctrl.sv =====
// Controller state machine of the packer.
// Depends on grp_pkg.
module grp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  grp_pkg::sts_t   sts_i,
  output grp_pkg::cmd_t   cmd_o
);
  grp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      grp_pkg::S_IDLE: if (in_valid_i) state_d = grp_pkg::S_READ;
      grp_pkg::S_READ: begin
        if (sts_i.kind) state_d = grp_pkg::S_OUT;
        else if (sts_i.scan_done) state_d = grp_pkg::S_OPEN;
        else state_d = grp_pkg::S_CHECK;
      end
      grp_pkg::S_CHECK: begin
        if (sts_i.fits) begin
          state_d = sts_i.bin_full ? grp_pkg::S_OUT : grp_pkg::S_SPLIT2;
        end else begin
          state_d = grp_pkg::S_READ;
        end
      end
      grp_pkg::S_SPLIT2: state_d = grp_pkg::S_OUT;
      grp_pkg::S_OPEN: begin
        if (sts_i.bins_full || !sts_i.type_ok) state_d = grp_pkg::S_OUT;
        else state_d = grp_pkg::S_OPEN2;
      end
      grp_pkg::S_OPEN2: state_d = grp_pkg::S_OUT;
      grp_pkg::S_OUT: if (out_ready_i) state_d = grp_pkg::S_IDLE;
      default: state_d = grp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      grp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      grp_pkg::S_READ: begin
        cmd_o.clear = sts_i.kind;
        cmd_o.rd    = !sts_i.kind && !sts_i.scan_done;
      end
      grp_pkg::S_CHECK: begin
        cmd_o.step     = !sts_i.fits;
        cmd_o.wr_below = sts_i.fits && !sts_i.bin_full;
        cmd_o.set_full = sts_i.fits && sts_i.bin_full;
      end
      grp_pkg::S_SPLIT2: cmd_o.wr_right = 1'b1;
      grp_pkg::S_OPEN: begin
        cmd_o.set_nosp = sts_i.bins_full || !sts_i.type_ok;
        cmd_o.open_bin = !(sts_i.bins_full || !sts_i.type_ok);
      end
      grp_pkg::S_OPEN2: cmd_o.wr_right = 1'b1;
      grp_pkg::S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/grp_dpath.sv =====
// Datapath of the packer: bin bookkeeping, scan pointer, split arithmetic.
// Depends on grp_pkg and grp_ram.
module grp_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  grp_pkg::in_item_t   in_data_i,
  input  grp_pkg::cmd_t       cmd_i,
  output grp_pkg::sts_t       sts_o,
  output grp_pkg::out_item_t  out_data_o
);
  localparam int unsigned CB = grp_pkg::CoordBits;

  logic [47:0] regs_q [grp_pkg::NumBinTypes];
  grp_pkg::in_item_t item_q;
  logic [grp_pkg::CntBits-1:0] cnt_q [grp_pkg::MaxBins];
  logic [1:0]  btype_q [grp_pkg::MaxBins];
  logic [grp_pkg::ObcBits-1:0] obc_q;
  logic [15:0] used_q [grp_pkg::NumBinTypes];
  // one bit wider than a bin index so the pointer can run past the last bin
  logic [grp_pkg::ObcBits-1:0]  sb_q;
  logic [grp_pkg::BinBits-1:0]  sbi;
  logic [grp_pkg::AreaBits-1:0] sa_q;
  grp_pkg::area_t hit_q;
  grp_pkg::out_item_t res_q;

  assign sbi = sb_q[grp_pkg::BinBits-1:0];

  logic [CB-1:0] iw, ih;
  assign iw = item_q.item_width[CB-1:0];
  assign ih = item_q.item_height[CB-1:0];

  // scan end: pointer past the last open bin
  logic [grp_pkg::CntBits-1:0] cur_cnt;
  assign cur_cnt = cnt_q[sbi];
  logic scan_done;
  assign scan_done = (sb_q >= obc_q);

  // bin type choice
  logic       type_ok;
  logic [1:0] tsel;
  always_comb begin
    type_ok = 1'b0;
    tsel    = '0;
    for (int t = grp_pkg::NumBinTypes - 1; t >= 0; t--) begin
      if (used_q[t] < regs_q[t][47:32] && regs_q[t][CB-1:0] >= iw &&
          regs_q[t][16+CB-1:16] >= ih) begin
        type_ok = 1'b1;
        tsel    = 2'(t);
      end
    end
  end

  // area memory
  logic we;
  logic [grp_pkg::AddrBits-1:0] waddr, raddr;
  logic [grp_pkg::AreaW-1:0] wdata, rdata;
  grp_pkg::area_t rarea;
  assign rarea = grp_pkg::area_t'(rdata);
  assign raddr = {sbi, sa_q};

  // split source: the area just read on a hit, else the held area
  grp_pkg::area_t src;
  assign src = cmd_i.wr_below ? rarea : hit_q;

  grp_pkg::area_t below, right, whole;
  logic [grp_pkg::BinBits-1:0] obin;
  assign obin = obc_q[grp_pkg::BinBits-1:0];
  always_comb begin
    below.x = src.x;
    below.y = src.y + ih;
    below.w = iw;
    below.h = src.h - ih;
    right.x = src.x + iw;
    right.y = src.y;
    right.w = src.w - iw;
    right.h = src.h;
    whole.x = '0;
    whole.y = '0;
    whole.w = regs_q[tsel][CB-1:0];
    whole.h = regs_q[tsel][16+CB-1:16];
  end

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = below;
    if (cmd_i.wr_below) begin
      we = 1'b1;
    end else if (cmd_i.wr_right) begin
      we    = 1'b1;
      waddr = {sbi, cur_cnt[grp_pkg::AreaBits-1:0]};
      wdata = right;
    end else if (cmd_i.open_bin) begin
      // below part of a fresh bin goes to slot 0
      we    = 1'b1;
      waddr = {obin, {grp_pkg::AreaBits{1'b0}}};
      wdata = {whole.x, whole.y + ih, iw, whole.h - ih};
    end
  end

  grp_ram #(.Width(grp_pkg::AreaW), .Depth(grp_pkg::MaxBins * grp_pkg::MaxAreas)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < grp_pkg::NumBinTypes; i++) begin
        regs_q[i] <= '0;
        used_q[i] <= '0;
      end
      for (int i = 0; i < grp_pkg::MaxBins; i++) cnt_q[i] <= '0;
      obc_q <= '0;
      sb_q  <= '0;
      sa_q  <= '0;
    end else begin
      if (cfg_we_i) regs_q[cfg_index_i] <= cfg_data_i;
      if (cmd_i.load) begin
        sb_q <= '0;
        sa_q <= '0;
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < grp_pkg::NumBinTypes; i++) used_q[i] <= '0;
        for (int i = 0; i < grp_pkg::MaxBins; i++) cnt_q[i] <= '0;
        obc_q <= '0;
      end
      if (cmd_i.step) begin
        if ({1'b0, sa_q} + 1'b1 >= {1'b0, cur_cnt}) begin
          sa_q <= '0;
          sb_q <= sb_q + 1'b1;
        end else begin
          sa_q <= sa_q + 1'b1;
        end
      end
      if (cmd_i.wr_right) cnt_q[sbi] <= cur_cnt + 1'b1;
      if (cmd_i.open_bin) begin
        used_q[tsel]  <= used_q[tsel] + 1'b1;
        cnt_q[obin]   <= grp_pkg::CntBits'(1);
        obc_q         <= obc_q + 1'b1;
        sb_q          <= {1'b0, obin};
      end
    end
  end

  // bin with empty list: skip on the check state by stepping via fits=0
  logic empty_bin;
  assign empty_bin = (cur_cnt == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      res_q  <= '0;
      res_q.out_id <= in_data_i.item_id;
    end
    if (cmd_i.clear) res_q.status <= grp_pkg::StCleared;
    if (cmd_i.set_full) res_q.status <= grp_pkg::StFull;
    if (cmd_i.set_nosp) res_q.status <= grp_pkg::StNoSpace;
    if (cmd_i.wr_below) begin
      hit_q <= rarea;
      res_q.status    <= grp_pkg::StPlaced;
      res_q.bin_index <= 4'(sbi);
      res_q.pos_x     <= 16'(rarea.x);
      res_q.pos_y     <= 16'(rarea.y);
      res_q.bin_type  <= btype_q[sbi];
    end
    if (cmd_i.open_bin) begin
      hit_q <= whole;
      btype_q[obin]   <= tsel;
      res_q.status    <= grp_pkg::StPlaced;
      res_q.bin_index <= 4'(obin);
      res_q.new_bin   <= 1'b1;
      res_q.bin_type  <= tsel;
    end
  end

  // when the bin under the pointer holds no areas, the read data is void
  assign sts_o.kind      = item_q.kind;
  assign sts_o.scan_done = scan_done;
  assign sts_o.fits      = !empty_bin && rarea.w >= iw && rarea.h >= ih;
  assign sts_o.bin_full  = cur_cnt >= grp_pkg::CntBits'(grp_pkg::MaxAreas);
  assign sts_o.bins_full = obc_q >= grp_pkg::ObcBits'(grp_pkg::MaxBins);
  assign sts_o.type_ok   = type_ok;
  assign out_data_o      = res_q;
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for guillotine_rect_packer: directed table then random rectangles,
// each result checked against a typed row or a packer model. Depends on grp_pkg.
`timescale 1ns / 1ps

module testbench;
  localparam int unsigned TimeoutCycles = 4000000;
  localparam int unsigned DrainCycles   = 1200;

  typedef enum logic [1:0] {
    RegTypeA = 2'd0, RegTypeB = 2'd1, RegTypeC = 2'd2, RegTypeD = 2'd3
  } reg_idx_e;

  localparam logic KindPlace = 1'b0;
  localparam logic KindClear = 1'b1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [47:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  grp_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  grp_pkg::out_item_t out_data_o;

  guillotine_rect_packer i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Packer shadow: bin type registers and the per-bin free area lists.
  logic [47:0]          bin_type_reg [4];
  grp_pkg::area_t       shadow_area [grp_pkg::MaxBins][grp_pkg::MaxAreas];
  int unsigned          shadow_count [grp_pkg::MaxBins];
  logic [1:0]           shadow_bin_type [grp_pkg::MaxBins];
  int unsigned          shadow_open;
  int unsigned          shadow_used [4];

  grp_pkg::out_item_t placements_due[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // Idle percentages for the two sides; the stall flag forces a long hold-off.
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 78;
  bit          recv_hold = 1'b0;

  function automatic void clear_shadow();
    shadow_open = 0;
    for (int b = 0; b < grp_pkg::MaxBins; b++) shadow_count[b] = 0;
    for (int t = 0; t < 4; t++) shadow_used[t] = 0;
  endfunction

  function automatic void split_area(int unsigned b, int unsigned slot, grp_pkg::area_t src,
                                     logic [15:0] w, logic [15:0] h);
    grp_pkg::area_t below, right;
    below.x = src.x;     below.y = src.y + h; below.w = w;         below.h = src.h - h;
    right.x = src.x + w; right.y = src.y;     right.w = src.w - w; right.h = src.h;
    shadow_area[b][slot] = below;
    shadow_area[b][shadow_count[b]] = right;
    shadow_count[b]++;
  endfunction

  // Work out the result of one rectangle or clear and advance the shadow.
  function automatic grp_pkg::out_item_t pack_item(grp_pkg::in_item_t it);
    grp_pkg::out_item_t res;
    grp_pkg::area_t     whole;
    logic [15:0]        bw, bh, qty;
    res = '0;
    res.out_id = it.item_id;
    if (it.kind == KindClear) begin
      clear_shadow();
      res.status = grp_pkg::StCleared;
      return res;
    end
    for (int unsigned b = 0; b < shadow_open; b++) begin
      for (int unsigned a = 0; a < shadow_count[b]; a++) begin
        if (shadow_area[b][a].w >= it.item_width && shadow_area[b][a].h >= it.item_height) begin
          if (shadow_count[b] >= grp_pkg::MaxAreas) begin
            res.status = grp_pkg::StFull;
            return res;
          end
          res.status = grp_pkg::StPlaced;
          res.bin_index = b[3:0];
          res.pos_x = shadow_area[b][a].x;
          res.pos_y = shadow_area[b][a].y;
          res.bin_type = shadow_bin_type[b];
          split_area(b, a, shadow_area[b][a], it.item_width, it.item_height);
          return res;
        end
      end
    end
    res.status = grp_pkg::StNoSpace;
    if (shadow_open >= grp_pkg::MaxBins) return res;
    for (int unsigned t = 0; t < grp_pkg::NumBinTypes; t++) begin
      bw = bin_type_reg[t][15:0];
      bh = bin_type_reg[t][31:16];
      qty = bin_type_reg[t][47:32];
      if (shadow_used[t] < qty && bw >= it.item_width && bh >= it.item_height) begin
        whole = '{x: '0, y: '0, w: bw, h: bh};
        shadow_bin_type[shadow_open] = t[1:0];
        shadow_used[t]++;
        shadow_count[shadow_open] = 1;
        split_area(shadow_open, 0, whole, it.item_width, it.item_height);
        res.status = grp_pkg::StPlaced;
        res.bin_index = shadow_open[3:0];
        res.new_bin = 1'b1;
        res.bin_type = t[1:0];
        shadow_open++;
        return res;
      end
    end
    return res;
  endfunction

  // Drive one transfer into the block and queue its expected result.
  // Valid stays high between back-to-back items; drop it only to idle.
  task automatic send_item(grp_pkg::in_item_t it);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_valid_i <= 1'b0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i iff in_ready_o);
    placements_due.push_back(pack_item(it));
  endtask

  task automatic write_reg(reg_idx_e idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    bin_type_reg[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every queued result has been transferred, plus settle time.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [47:0] bin_reg(int w, int h, int q);
    return {q[15:0], h[15:0], w[15:0]};
  endfunction

  function automatic grp_pkg::in_item_t rect(int id, int w, int h);
    grp_pkg::in_item_t it;
    it.kind = KindPlace;
    it.item_id = id[15:0];
    it.item_width = w[15:0];
    it.item_height = h[15:0];
    return it;
  endfunction

  // Receiver: random back-pressure, compare each result transfer field by field.
  always @(posedge clk_i) begin
    grp_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (placements_due.size() == 0) begin
          $error("unexpected result transfer: %p", out_data_o);
          errors++;
        end else begin
          want = placements_due.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status); errors++;
          end
          if (out_data_o.out_id !== want.out_id) begin
            $error("out_id: expected %0d, got %0d", want.out_id, out_data_o.out_id); errors++;
          end
          if (out_data_o.bin_index !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, out_data_o.bin_index);
            errors++;
          end
          if (out_data_o.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, out_data_o.pos_x); errors++;
          end
          if (out_data_o.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, out_data_o.pos_y); errors++;
          end
          if (out_data_o.new_bin !== want.new_bin) begin
            $error("new_bin: expected %0d, got %0d", want.new_bin, out_data_o.new_bin); errors++;
          end
          if (out_data_o.bin_type !== want.bin_type) begin
            $error("bin_type: expected %0d, got %0d", want.bin_type, out_data_o.bin_type);
            errors++;
          end
        end
      end
      out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("guillotine_rect_packer regression: fail");
      $finish;
    end
  end

  // Directed rows: expected result typed in where obvious, else predicted.
  typedef struct {
    grp_pkg::in_item_t  item;
    bit                 typed;
    grp_pkg::out_item_t res;
  } row_t;

  row_t directed[$];

  function automatic grp_pkg::out_item_t status_only(logic [1:0] st, int id);
    grp_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.out_id = id[15:0];
    return r;
  endfunction

  task automatic run_phase(int n, int wmax, int hmax, int clear_pct);
    grp_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rect($urandom, $urandom_range(wmax), $urandom_range(hmax));
      if ($urandom_range(99) < clear_pct) it.kind = KindClear;
      else if ($urandom_range(99) < 3) begin
        it.item_width = 16'($urandom);
        it.item_height = 16'($urandom);
      end
      send_item(it);
    end
  endtask

  initial begin
    grp_pkg::out_item_t got;
    grp_pkg::in_item_t  clr;
    for (int t = 0; t < 4; t++) bin_type_reg[t] = '0;
    for (int b = 0; b < grp_pkg::MaxBins; b++) shadow_bin_type[b] = '0;
    clear_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every type register is zero: nothing can be opened.
    directed.push_back('{rect(1, 1, 1), 1, status_only(grp_pkg::StNoSpace, 1)});
    directed.push_back('{rect(2, 0, 0), 1, status_only(grp_pkg::StNoSpace, 2)});
    clr = '0; clr.kind = KindClear; clr.item_id = 16'hFFFF;
    directed.push_back('{clr, 1, status_only(grp_pkg::StCleared, 16'hFFFF)});
    foreach (directed[i]) begin
      send_item(directed[i].item);
      got = placements_due.pop_back();
      placements_due.push_back(directed[i].typed ? directed[i].res : got);
    end
    drain();

    // Extremes: a full-size type with quantity 1, tiny types, zero quantity.
    write_reg(RegTypeA, bin_reg(65535, 65535, 1));
    write_reg(RegTypeB, bin_reg(4, 4, 2));
    write_reg(RegTypeC, bin_reg(0, 0, 65535));
    write_reg(RegTypeD, bin_reg(100, 100, 0));
    directed.delete();
    directed.push_back('{rect(10, 65535, 1), 0, '0});
    directed.push_back('{rect(11, 1, 65535), 0, '0});   // below strip too short
    directed.push_back('{rect(12, 0, 0), 0, '0});       // zero size fits anywhere
    directed.push_back('{rect(13, 4, 4), 0, '0});
    directed.push_back('{rect(14, 5, 5), 0, '0});
    directed.push_back('{rect(15, 65535, 65535), 0, '0});
    directed.push_back('{rect(16, 3, 3), 0, '0});
    directed.push_back('{rect(17, 4, 4), 0, '0});
    directed.push_back('{rect(18, 4, 4), 0, '0});
    directed.push_back('{clr, 1, status_only(grp_pkg::StCleared, 16'hFFFF)});
    directed.push_back('{rect(19, 65535, 65535), 0, '0});
    // Grow one bin's area list with zero-size items, short of full.
    for (int i = 0; i < 14; i++) directed.push_back('{rect(20 + i, 0, 0), 0, '0});
    foreach (directed[i]) begin
      send_item(directed[i].item);
      got = placements_due.pop_back();
      placements_due.push_back(directed[i].typed ? directed[i].res : got);
    end
    drain();

    // Many zero-size items: exercise area list full.
    write_reg(RegTypeA, bin_reg(8, 8, 1));
    write_reg(RegTypeB, 48'h0);
    write_reg(RegTypeC, 48'h0);
    write_reg(RegTypeD, 48'h0);
    for (int i = 0; i < 40; i++) send_item(rect(100 + i, 0, 0));
    send_item(clr);
    drain();

    // Random phases with several bin type settings.
    write_reg(RegTypeA, bin_reg(40, 30, 3));
    write_reg(RegTypeB, bin_reg(64, 64, 5));
    write_reg(RegTypeC, bin_reg(20, 80, 4));
    write_reg(RegTypeD, bin_reg(128, 16, 6));
    run_phase(350, 24, 24, 4);
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 36;
    write_reg(RegTypeA, bin_reg($urandom, $urandom, $urandom_range(3)));
    write_reg(RegTypeB, bin_reg(16, 16, 20));
    write_reg(RegTypeC, 48'({$urandom, $urandom}));
    write_reg(RegTypeD, bin_reg(65535, 65535, 65535));
    run_phase(350, 40, 40, 5);
    drain();

    // Long receiver hold-off while items keep coming, then a sender pause.
    recv_hold = 1'b1;
    fork
      run_phase(6, 8, 8, 0);
      begin
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegTypeA, bin_reg(32, 32, 16));
    write_reg(RegTypeB, bin_reg(12, 48, 4));
    write_reg(RegTypeC, bin_reg(48, 12, 4));
    write_reg(RegTypeD, 48'hFFFF_FFFF_FFFF);
    run_phase(420, 16, 16, 3);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && placements_due.size() == 0) begin
      $display("guillotine_rect_packer regression: pass");
    end else begin
      $display("guillotine_rect_packer regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/grp_pkg.sv
hw/rtl/grp_ram.sv
hw/rtl/grp_ctrl.sv
hw/rtl/grp_dpath.sv
hw/rtl/guillotine_rect_packer.sv
tb/sv/testbench.sv
